[src/hbpr_pkg.sv]
// ---------------------------------------------------------------------------
// hbpr_pkg: shared types and constants for the H-bridge pump run controller
// Codes for commands, phases and directions, register indexes, reset
// values of the configuration registers and the word structs.
// ---------------------------------------------------------------------------
package hbpr_pkg;

   // Configuration register file
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int TIMEOUT_WIDTH   = 32;
   localparam int DEAD_TIME_WIDTH = 16;
   localparam int TICKS_WIDTH     = 32;

   localparam logic [TIMEOUT_WIDTH-1:0]   WATCHDOG_RESET  = 32'd60000;
   localparam logic [DEAD_TIME_WIDTH-1:0] DEAD_TIME_RESET = 16'd50;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WATCHDOG  = 1'b0,
      CSR_DEAD_TIME = 1'b1
   } csr_index_type;

   // Item kind
   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_COMMAND = 1'b1
   } op_type;

   // Drive direction; the unused code acts as stop
   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   // Controller phase, also the reported phase code
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_RUN     = 2'd1,
      PH_TIMEOUT = 2'd2,
      PH_DEAD    = 2'd3
   } phase_type;

   // One input word
   typedef struct packed {
      op_type                 op;
      logic [1:0]             direction;
      logic                   timed;
      logic [TICKS_WIDTH-1:0] run_length;
   } req_item_type;

   // Live configuration
   typedef struct packed {
      logic [TIMEOUT_WIDTH-1:0]   watchdog_timeout;
      logic [DEAD_TIME_WIDTH-1:0] dead_time;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic                   drive_a;
      logic                   drive_b;
      logic                   running;
      phase_type              phase_code;
      logic [TICKS_WIDTH-1:0] remaining;
   } rsp_item_type;

endpackage

[src/hbridge_pump_run_controller_unit.sv]
// ---------------------------------------------------------------------------
// hbridge_pump_run_controller_unit: H-bridge pump run controller
// Takes tick and drive command words, drives the two bridge inputs and
// reports running state, phase and remaining time of a timed run.
// ---------------------------------------------------------------------------
// Path: an accepted input word goes through the input register, then the result
// register, where rsp_valid rises; a result-side stall can hold it in between.
// Throughput: one word per cycle; the only stall comes from the result side.
// Reset: synchronous; clears the run state to idle/stop and loads the
// watchdog timeout (60000) and reverse dead time (50) defaults.
module hbridge_pump_run_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [1:0]                          req_direction,
   input  logic                                req_timed,
   input  logic [hbpr_pkg::TICKS_WIDTH-1:0]    req_run_length,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_drive_a,
   output logic                                rsp_drive_b,
   output logic                                rsp_running,
   output logic [1:0]                          rsp_phase_code,
   output logic [hbpr_pkg::TICKS_WIDTH-1:0]    rsp_remaining,
   // configuration writes
   input  logic                                csr_we,
   input  logic [hbpr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hbpr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import hbpr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type step_result;
   cfg_type      cfg_ff, cfg_in;
   logic         advance;
   logic         req_take;

   // Move the held word into the result register when it is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WATCHDOG:  cfg_in.watchdog_timeout = csr_wdata[TIMEOUT_WIDTH-1:0];
            CSR_DEAD_TIME: cfg_in.dead_time        = csr_wdata[DEAD_TIME_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watchdog_timeout <= WATCHDOG_RESET;
         cfg_ff.dead_time        <= DEAD_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: hold the word until it moves on
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.op         <= op_type'(req_op);
         in_item_ff.direction  <= req_direction;
         in_item_ff.timed      <= req_timed;
         in_item_ff.run_length <= req_run_length;
      end
   end

   // Step logic and run state
   hbpr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   // Result register: load on advance, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_a    = rsp_item_ff.drive_a;
   assign rsp_drive_b    = rsp_item_ff.drive_b;
   assign rsp_running    = rsp_item_ff.running;
   assign rsp_phase_code = rsp_item_ff.phase_code;
   assign rsp_remaining  = rsp_item_ff.remaining;

   // A held word that can move always shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !(rsp_valid_ff && rsp_stall)) |=> rsp_valid_ff)
      else $error("held word did not reach the result register");

   // Both bridge inputs high would short the bridge
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_drive_a && rsp_drive_b))
      else $error("both bridge inputs driven");

   // Running flag follows the phase code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_running == (rsp_phase_code == PH_RUN)))
      else $error("running flag disagrees with phase");

   // Remaining time only during a run or its dead time
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_remaining != '0)
      |-> (rsp_phase_code == PH_RUN || rsp_phase_code == PH_DEAD))
      else $error("remaining time reported while stopped");

endmodule

[src/hbpr_core.sv]
// ---------------------------------------------------------------------------
// hbpr_core: run state and single-pass step logic
// Holds the controller state, works out the state after one word and the
// result word that shows it. State advances only when advance is high.
// ---------------------------------------------------------------------------
module hbpr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  hbpr_pkg::req_item_type item,
   input  hbpr_pkg::cfg_type     cfg,
   output hbpr_pkg::rsp_item_type result
);
   import hbpr_pkg::*;

   phase_type                  phase_ff, phase_in;
   dir_type                    dir_ff, dir_in;
   logic                       timed_active_ff, timed_active_in;
   logic [TICKS_WIDTH-1:0]     elapsed_ff, elapsed_in;
   logic [TICKS_WIDTH-1:0]     length_ff, length_in;
   logic [DEAD_TIME_WIDTH-1:0] dead_left_ff, dead_left_in;

   logic [TICKS_WIDTH-1:0]     elapsed_inc;
   logic [DEAD_TIME_WIDTH-1:0] dead_dec;
   dir_type                    cmd_dir;
   logic                       cmd_drive;

   // Decode the command direction; the unused code means stop
   always_comb begin
      unique case (dir_type'(item.direction))
         DIR_FWD: cmd_dir = DIR_FWD;
         DIR_REV: cmd_dir = DIR_REV;
         default: cmd_dir = DIR_STOP;
      endcase
      cmd_drive = (cmd_dir != DIR_STOP);
   end

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign dead_dec    = dead_left_ff - 1'b1;

   // Next state
   always_comb begin
      phase_in        = phase_ff;
      dir_in          = dir_ff;
      timed_active_in = timed_active_ff;
      elapsed_in      = elapsed_ff;
      length_in       = length_ff;
      dead_left_in    = dead_left_ff;

      if (item.op == OP_COMMAND) begin
         if (!cmd_drive) begin
            // stop: halt, drop any timed run
            phase_in        = PH_IDLE;
            dir_in          = DIR_STOP;
            timed_active_in = 1'b0;
         end else begin
            // new direction or not running: restart, going through dead time for reverse when it is nonzero
            if (!(phase_ff == PH_RUN && dir_ff == cmd_dir)) begin
               dir_in          = cmd_dir;
               timed_active_in = 1'b0;
               elapsed_in      = '0;
               if (cmd_dir == DIR_REV && cfg.dead_time != '0) begin
                  phase_in     = PH_DEAD;
                  dead_left_in = cfg.dead_time;
               end else begin
                  phase_in = PH_RUN;
               end
            end
            // timed command always restarts its timer
            if (item.timed) begin
               timed_active_in = 1'b1;
               elapsed_in      = '0;
               length_in       = item.run_length;
            end
         end
      end else begin
         case (phase_ff)
            PH_DEAD: begin
               // count down the dead time, then start reverse drive
               dead_left_in = dead_dec;
               if (dead_dec == '0) begin
                  phase_in   = PH_RUN;
                  elapsed_in = '0;
               end
            end
            PH_TIMEOUT: begin
               phase_in        = PH_IDLE;
               dir_in          = DIR_STOP;
               timed_active_in = 1'b0;
            end
            PH_RUN: begin
               // advance the saturating elapsed count and check the limit
               elapsed_in = elapsed_inc;
               if (timed_active_ff) begin
                  if (elapsed_inc >= length_ff) begin
                     phase_in        = PH_IDLE;
                     dir_in          = DIR_STOP;
                     timed_active_in = 1'b0;
                  end
               end else if (elapsed_inc >= cfg.watchdog_timeout) begin
                  phase_in        = PH_TIMEOUT;
                  dir_in          = DIR_STOP;
                  timed_active_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result word from the new state
   always_comb begin
      result.drive_a    = (phase_in == PH_RUN) && (dir_in == DIR_FWD);
      result.drive_b    = (phase_in == PH_RUN) && (dir_in == DIR_REV);
      result.running    = (phase_in == PH_RUN);
      result.phase_code = phase_in;
      if (timed_active_in && (elapsed_in < length_in)) begin
         result.remaining = length_in - elapsed_in;
      end else begin
         result.remaining = '0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         dir_ff          <= DIR_STOP;
         timed_active_ff <= 1'b0;
         elapsed_ff      <= '0;
         length_ff       <= '0;
         dead_left_ff    <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         dir_ff          <= dir_in;
         timed_active_ff <= timed_active_in;
         elapsed_ff      <= elapsed_in;
         length_ff       <= length_in;
         dead_left_ff    <= dead_left_in;
      end
   end

   // Dead time is never entered with a zero count
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEAD) |-> (dead_left_ff != '0))
      else $error("dead time phase with zero count");

   // A timed run never lingers once the phase has left running or dead time
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE || phase_ff == PH_TIMEOUT) |-> !timed_active_ff)
      else $error("timed run active while stopped");

   // Leaving dead time on a tick always starts the run from zero
   assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_DEAD && item.op == OP_TICK && phase_in == PH_RUN)
      |=> (elapsed_ff == '0))
      else $error("reverse run did not start from zero");

endmodule
